### hdl/lbie_pkg.sv
// ----------------------------------------------------------------------------
// lbie_pkg
// Shared types, constants and bit-scan / rotate helpers for the logical
// bitmask immediate encoder.
// ----------------------------------------------------------------------------
package lbie_pkg;

  localparam int WordBits = 64;
  localparam int HalfBits = 32;
  localparam int FieldW   = 6;
  localparam int CntW     = 7;

  typedef logic [WordBits-1:0] word_t;
  typedef logic [HalfBits-1:0] half_t;
  typedef logic [FieldW-1:0]   field_t;
  typedef logic [CntW-1:0]     cnt_t;

  localparam field_t FieldMask = 6'b111111;

  // trailing-zero count, full width when the word is zero
  function automatic cnt_t count_tz(input word_t w);
    cnt_t n;
    n = cnt_t'(WordBits);
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (w[i]) n = cnt_t'(i);
    end
    return n;
  endfunction

  // leading-zero count, full width when the word is zero
  function automatic cnt_t count_lz(input word_t w);
    cnt_t n;
    n = cnt_t'(WordBits);
    for (int i = 0; i < WordBits; i++) begin
      if (w[i]) n = cnt_t'(WordBits - 1 - i);
    end
    return n;
  endfunction

  // rotate right, amount taken mod word width
  function automatic word_t rot_right(input word_t w, input field_t amt);
    logic [2*WordBits-1:0] dbl;
    dbl = {w, w} >> amt;
    return dbl[WordBits-1:0];
  endfunction

endpackage

### hdl/logical_bitmask_immediate_encoder_core.sv
// ----------------------------------------------------------------------------
// logical_bitmask_immediate_encoder_core
// Five-stage pipelined encoder of logical bitmask immediates (N, immr, imms).
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_stall is low and returns one result word
// per input word. Stage 1 replicates a narrow value and clears the trailing
// ones, stage 2 counts the rotation, stage 3 rotates the value into normal
// form, stage 4 counts the element size and ones, stage 5 checks the repeat
// and forms the fields. Each stage holds its own valid bit and moves whenever
// the stage after it has room, so bubbles close up under an output stall.
// Values that are all zeros, all ones or not a repeated rotated run give
// valid_res low and zero fields.
module logical_bitmask_immediate_encoder_core
  import lbie_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value,
  input  logic        in_narrow,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_valid_res,
  output logic        out_n_bit,
  output logic [5:0]  out_rotate_field,
  output logic [5:0]  out_size_ones_field
);

  localparam int NumStages = 5;

  logic [NumStages-1:0] v_r;
  logic [NumStages-1:0] adv;

  word_t  w1_r, c1_r;
  logic   spec1_r;
  word_t  w2_r;
  cnt_t   rot2_r;
  logic   spec2_r;
  word_t  w3_r, norm3_r;
  cnt_t   rot3_r;
  logic   spec3_r;
  word_t  w4_r;
  cnt_t   rot4_r, size4_r, ones4_r;
  logic   spec4_r;
  logic   res_r, n_r;
  field_t immr_r, imms_r;

  word_t  w_in;
  logic   ok5;
  cnt_t   size_m1, ones_m1;
  field_t immr_nxt, imms_nxt;

  always_comb begin
    adv[NumStages-1] = !v_r[NumStages-1] || !out_stall;
    for (int i = NumStages - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NumStages; i++) begin
        if (adv[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  always_comb begin
    w_in = in_narrow ? {in_value[HalfBits-1:0], in_value[HalfBits-1:0]} : in_value;
  end

  always_comb begin
    ok5      = !spec4_r && (rot_right(w4_r, size4_r[FieldW-1:0]) == w4_r);
    size_m1  = size4_r - cnt_t'(1);
    ones_m1  = ones4_r - cnt_t'(1);
    immr_nxt = (field_t'(0) - rot4_r[FieldW-1:0]) & size_m1[FieldW-1:0] & FieldMask;
    imms_nxt = ((field_t'(0) - {size4_r[FieldW-2:0], 1'b0}) | ones_m1[FieldW-1:0])
               & FieldMask;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      w1_r    <= w_in;
      c1_r    <= w_in & (w_in + word_t'(1));
      spec1_r <= (w_in == '0) || (w_in == '1);
    end
    if (adv[1]) begin
      w2_r    <= w1_r;
      rot2_r  <= count_tz(c1_r);
      spec2_r <= spec1_r;
    end
    if (adv[2]) begin
      w3_r    <= w2_r;
      norm3_r <= rot_right(w2_r, rot2_r[FieldW-1:0]);
      rot3_r  <= rot2_r;
      spec3_r <= spec2_r;
    end
    if (adv[3]) begin
      w4_r    <= w3_r;
      rot4_r  <= rot3_r;
      size4_r <= count_lz(norm3_r) + count_tz(~norm3_r);
      ones4_r <= count_tz(~norm3_r);
      spec4_r <= spec3_r;
    end
    if (adv[4]) begin
      res_r  <= ok5;
      n_r    <= ok5 & size4_r[CntW-1];
      immr_r <= ok5 ? immr_nxt : '0;
      imms_r <= ok5 ? imms_nxt : '0;
    end
  end

  assign out_valid           = v_r[NumStages-1];
  assign out_valid_res       = res_r;
  assign out_n_bit           = n_r;
  assign out_rotate_field    = immr_r;
  assign out_size_ones_field = imms_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_valid_res) |->
      (!out_n_bit && out_rotate_field == '0 && out_size_ones_field == '0))
    else $error("invalid result carries nonzero fields");

  a_imms_not_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_valid_res) |-> (out_size_ones_field != FieldMask))
    else $error("imms encodes a full element of ones");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted word missing from first stage");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the logical bitmask immediate encoder core.
// ----------------------------------------------------------------------------
// A table of directed words covers the all-zero and all-one values, narrow
// replication with junk in the upper half, single-bit and near-full runs and
// the two-bit element patterns. Random words follow, most of them built as
// rotated runs replicated across an element size, the rest bit flips, raw
// noise and degenerate values. Each result is checked in order against the
// table or behavioral encoder; both channels idle at phase-dependent rates.
module tb;
  import lbie_pkg::*;

  localparam int NumDirected = 22;
  localparam int RandomWords = 1850;
  localparam int NumPhases   = 3;

  typedef struct packed {
    logic   valid_res;
    logic   n_bit;
    field_t rotate;
    field_t size_ones;
  } enc_result_t;

  typedef struct packed {
    word_t       value;
    logic        narrow;
    logic        known;
    enc_result_t result;
  } stim_row_t;

  localparam enc_result_t NoEncoding = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_value = '0;
  logic        in_narrow = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_valid_res;
  logic        out_n_bit;
  logic [5:0]  out_rotate_field;
  logic [5:0]  out_size_ones_field;

  enc_result_t expected_results[$];
  enc_result_t got_result;
  enc_result_t want_result;
  int          mismatch_count = 0;
  int          send_gap_pct = 13;
  int          recv_stall_pct = 73;

  stim_row_t directed_rows [NumDirected] = '{
    '{64'h0000_0000_0000_0000, 1'b0, 1'b1, NoEncoding},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, NoEncoding},
    '{64'hFFFF_FFFF_0000_0000, 1'b1, 1'b1, NoEncoding},
    '{64'h0000_0000_FFFF_FFFF, 1'b1, 1'b1, NoEncoding},
    '{64'h0000_0000_0000_0001, 1'b0, 1'b1, '{1'b1, 1'b1, 6'd0, 6'd0}},
    '{64'h8000_0000_0000_0000, 1'b0, 1'b1, '{1'b1, 1'b1, 6'd1, 6'd0}},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, '{1'b1, 1'b1, 6'd0, 6'd62}},
    '{64'h5555_5555_5555_5555, 1'b0, 1'b1, '{1'b1, 1'b0, 6'd0, 6'd60}},
    '{64'h1234_5678_AAAA_AAAA, 1'b1, 1'b1, '{1'b1, 1'b0, 6'd1, 6'd60}},
    '{64'h0000_0000_0000_0005, 1'b0, 1'b1, NoEncoding},
    '{64'h0000_0000_0000_00FF, 1'b0, 1'b0, NoEncoding},
    '{64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, NoEncoding},
    '{64'h00FF_00FF_00FF_00FF, 1'b0, 1'b0, NoEncoding},
    '{64'hDEAD_BEEF_0000_FFFF, 1'b1, 1'b0, NoEncoding},
    '{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0, NoEncoding},
    '{64'h0000_000F_0000_0000, 1'b0, 1'b0, NoEncoding},
    '{64'hFFFF_FFFF_8000_0000, 1'b1, 1'b0, NoEncoding},
    '{64'h0000_0000_0000_0001, 1'b1, 1'b0, NoEncoding},
    '{64'h3333_3333_3333_3333, 1'b0, 1'b0, NoEncoding},
    '{64'h0000_FFFF_0001_FFFF, 1'b0, 1'b0, NoEncoding},
    '{64'hFFFF_FFFE_FFFF_FFFE, 1'b0, 1'b0, NoEncoding},
    '{64'hAAAA_AAAA_7FFF_FFFF, 1'b1, 1'b0, NoEncoding}
  };

  logical_bitmask_immediate_encoder_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_value            (in_value),
    .in_narrow           (in_narrow),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_valid_res       (out_valid_res),
    .out_n_bit           (out_n_bit),
    .out_rotate_field    (out_rotate_field),
    .out_size_ones_field (out_size_ones_field)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic word_t spin_right(input word_t w, input int amt);
    int sh;
    sh = amt % 64;
    if (sh == 0) return w;
    return (w >> sh) | (w << (64 - sh));
  endfunction

  function automatic enc_result_t encode_bitmask_imm(input word_t value, input logic narrow);
    word_t       w;
    word_t       cleared;
    word_t       norm;
    int          rotation;
    int          zeroes;
    int          ones;
    int          elem_size;
    enc_result_t r;
    r = NoEncoding;
    w = narrow ? {value[31:0], value[31:0]} : value;
    if (w == '0 || w == '1) return r;
    cleared = w & (w + 64'd1);
    rotation = 64;
    for (int i = 63; i >= 0; i--) if (cleared[i]) rotation = i;
    norm = spin_right(w, rotation);
    zeroes = 64;
    for (int i = 0; i < 64; i++) if (norm[i]) zeroes = 63 - i;
    ones = 64;
    for (int i = 63; i >= 0; i--) if (!norm[i]) ones = i;
    elem_size = zeroes + ones;
    if (spin_right(w, elem_size) != w) return r;
    r.valid_res = 1'b1;
    r.n_bit     = 1'((elem_size >> 6) & 1);
    r.rotate    = field_t'((-rotation) & (elem_size - 1));
    r.size_ones = field_t'((-(elem_size * 2)) | (ones - 1));
    return r;
  endfunction

  task automatic pick_word(output word_t v, output logic nw);
    int    kind;
    int    esize;
    int    run_len;
    int    rot;
    word_t run;
    kind    = $urandom_range(99);
    esize   = 2 << $urandom_range(5);
    run_len = $urandom_range(esize - 1, 1);
    rot     = $urandom_range(esize - 1, 0);
    run     = (64'd1 << run_len) - 64'd1;
    v       = '0;
    for (int i = 0; i < 64; i += esize) v |= run << i;
    v  = spin_right(v, rot);
    nw = 1'b0;
    if (kind < 75) begin
      if (esize <= 32 && $urandom_range(1) == 1) begin
        nw = 1'b1;
        v[63:32] = $urandom;
      end
    end else if (kind < 85) begin
      v[$urandom_range(63)] ^= 1'b1;
      nw = 1'($urandom_range(1));
    end else if (kind < 95) begin
      v  = {$urandom, $urandom};
      nw = 1'($urandom_range(1));
    end else begin
      v  = $urandom_range(1) ? '1 : '0;
      nw = 1'($urandom_range(1));
      if (nw) v[63:32] = $urandom;
    end
  endtask

  // hold the word until taken, then leave a random gap
  task automatic send_word(input word_t v, input logic nw, input enc_result_t exp);
    logic taken;
    int   gap;
    in_value  <= v;
    in_narrow <= nw;
    in_valid  <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    expected_results.push_back(exp);
    gap = 0;
    while ($urandom_range(99) < send_gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result = '{out_valid_res, out_n_bit, out_rotate_field, out_size_ones_field};
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected word: valid_res=%b n=%b immr=%0d imms=%0d",
                               got_result.valid_res, got_result.n_bit,
                               got_result.rotate, got_result.size_ones));
      end else begin
        want_result = expected_results.pop_front();
        if (got_result !== want_result) begin
          note_failure($sformatf({"mismatch: exp valid_res=%b n=%b immr=%0d imms=%0d, ",
                                  "got valid_res=%b n=%b immr=%0d imms=%0d"},
                                 want_result.valid_res, want_result.n_bit,
                                 want_result.rotate, want_result.size_ones,
                                 got_result.valid_res, got_result.n_bit,
                                 got_result.rotate, got_result.size_ones));
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin
    word_t       v;
    logic        nw;
    enc_result_t exp;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i]) begin
      exp = directed_rows[i].known ? directed_rows[i].result
                                   : encode_bitmask_imm(directed_rows[i].value,
                                                        directed_rows[i].narrow);
      send_word(directed_rows[i].value, directed_rows[i].narrow, exp);
    end
    for (int ph = 0; ph < NumPhases; ph++) begin
      send_gap_pct   = (ph == 0) ? 13 : (ph == 1) ? 73 : 0;
      recv_stall_pct = (ph == 0) ? 73 : (ph == 1) ? 13 : 0;
      for (int n = 0; n < RandomWords / NumPhases; n++) begin
        pick_word(v, nw);
        send_word(v, nw, encode_bitmask_imm(v, nw));
      end
    end
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
